// File: rtl/wdp_pkg.sv
package wdp_pkg;

  localparam int unsigned COORD_W    = 12;
  localparam int unsigned HIST_DEPTH = 5;
  localparam int unsigned COUNT_W    = 3;
  localparam int unsigned PRED_W     = 14;

  localparam int unsigned IN_DATA_W  = ((2 * COORD_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((2 * PRED_W + COUNT_W + 7) / 8) * 8;

  localparam logic [COUNT_W-1:0] COUNT_EMPTY = COUNT_W'(0);
  localparam logic [COUNT_W-1:0] COUNT_ONE   = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] COUNT_TWO   = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] COUNT_THREE = COUNT_W'(3);
  localparam logic [COUNT_W-1:0] COUNT_FOUR  = COUNT_W'(4);
  localparam logic [COUNT_W-1:0] COUNT_FULL  = COUNT_W'(HIST_DEPTH);

  // index 0 is the newest point
  typedef logic [HIST_DEPTH-1:0][COORD_W-1:0] hist_t;

endpackage

// File: rtl/weighted_delta_position_predictor.sv
// Weighted-delta position predictor.
// Input stream: one word per observed center of a tracked object.
//   s_axis_tdata: center_x, center_y; s_axis_tuser: start_track.
//   start_track clears the track; the first word after reset starts one too.
// Output stream: one word per input word, in order.
//   m_axis_tdata: predicted_x, predicted_y (two's complement), points_held.
// Prediction is the newest center plus the rounded, linearly weighted
// mean of up to four recent deltas over a five-point history.
// Pipeline: the history registers take the word at accept; the prediction
// logic then fills the output register. Throughput: one word per cycle
// while the receiver accepts.
// Stall: when the receiver holds off, the output word is held, one more
// result waits in the history stage, and s_axis_tready drops only when
// both are full. No word is lost or repeated.
// Reset: the point count clears, so the next word begins a new track;
// both stream sides are empty after reset.
module weighted_delta_position_predictor (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [wdp_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // center_x, center_y
  input  logic                              s_axis_tuser,  // start_track
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [wdp_pkg::OUT_DATA_W-1:0]    m_axis_tdata   // predicted_x, predicted_y, points_held
);

  localparam int unsigned CW = wdp_pkg::COORD_W;
  localparam int unsigned PW = wdp_pkg::PRED_W;
  localparam int unsigned NW = wdp_pkg::COUNT_W;

  logic                       s_accept;
  logic                       stage_adv;
  logic                       out_free;
  logic                       stage_vld_q;
  logic                       out_vld_q;
  wdp_pkg::hist_t             hist_x, hist_y;
  logic [NW-1:0]              count;
  logic signed [PW-1:0]       pred_x, pred_y;
  logic signed [PW-1:0]       out_x_q, out_y_q;
  logic [NW-1:0]              out_n_q;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign stage_adv     = stage_vld_q && out_free;
  assign s_axis_tready = !stage_vld_q || out_free;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  wdp_history u_history (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (s_accept),
    .start_i  (s_axis_tuser),
    .cx_i     (s_axis_tdata[CW-1:0]),
    .cy_i     (s_axis_tdata[2*CW-1:CW]),
    .hist_x_o (hist_x),
    .hist_y_o (hist_y),
    .count_o  (count)
  );

  wdp_axis_pred u_pred_x (
    .hist_i  (hist_x),
    .count_i (count),
    .pred_o  (pred_x)
  );

  wdp_axis_pred u_pred_y (
    .hist_i  (hist_y),
    .count_i (count),
    .pred_o  (pred_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_vld_q <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      if (s_accept) begin
        stage_vld_q <= 1'b1;
      end else if (stage_adv) begin
        stage_vld_q <= 1'b0;
      end
      if (stage_adv) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_adv) begin
      out_x_q <= pred_x;
      out_y_q <= pred_y;
      out_n_q <= count;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = wdp_pkg::OUT_DATA_W'({out_n_q, out_y_q, out_x_q});

endmodule

// File: rtl/wdp_history.sv
module wdp_history (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic                          start_i,
  input  logic [wdp_pkg::COORD_W-1:0]   cx_i,
  input  logic [wdp_pkg::COORD_W-1:0]   cy_i,
  output wdp_pkg::hist_t                hist_x_o,
  output wdp_pkg::hist_t                hist_y_o,
  output logic [wdp_pkg::COUNT_W-1:0]   count_o
);

  wdp_pkg::hist_t                hist_x_q, hist_x_d;
  wdp_pkg::hist_t                hist_y_q, hist_y_d;
  logic [wdp_pkg::COUNT_W-1:0]   count_q, count_d;

  always_comb begin
    hist_x_d    = hist_x_q;
    hist_y_d    = hist_y_q;
    hist_x_d[0] = cx_i;
    hist_y_d[0] = cy_i;
    for (int i = 1; i < wdp_pkg::HIST_DEPTH; i++) begin
      hist_x_d[i] = hist_x_q[i-1];
      hist_y_d[i] = hist_y_q[i-1];
    end
    if (start_i || (count_q == wdp_pkg::COUNT_EMPTY)) begin
      count_d = wdp_pkg::COUNT_ONE;
    end else if (count_q < wdp_pkg::COUNT_FULL) begin
      count_d = count_q + wdp_pkg::COUNT_ONE;
    end else begin
      count_d = wdp_pkg::COUNT_FULL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= wdp_pkg::COUNT_EMPTY;
    end else if (load_i) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      hist_x_q <= hist_x_d;
      hist_y_q <= hist_y_d;
    end
  end

  assign hist_x_o = hist_x_q;
  assign hist_y_o = hist_y_q;
  assign count_o  = count_q;

endmodule

// File: rtl/wdp_axis_pred.sv
module wdp_axis_pred (
  input  wdp_pkg::hist_t                       hist_i,
  input  logic [wdp_pkg::COUNT_W-1:0]          count_i,
  output logic signed [wdp_pkg::PRED_W-1:0]    pred_o
);

  localparam int unsigned SUM_W  = wdp_pkg::COORD_W + 3;
  localparam int unsigned MAG_W  = SUM_W - 1;
  localparam int unsigned A_W    = wdp_pkg::COORD_W + 4;
  localparam int unsigned K      = A_W + 5;
  localparam int unsigned R_W    = K - 2;
  localparam int unsigned PSUM_W = SUM_W + 1;
  localparam int unsigned CMP_W  = (PSUM_W > wdp_pkg::PRED_W) ? PSUM_W : wdp_pkg::PRED_W;

  // ceil(2^K / (2*d)) for d = 3, 6, 10
  localparam logic [R_W-1:0] RCP3  = R_W'(((64'd1 << K) + 64'd5) / 64'd6);
  localparam logic [R_W-1:0] RCP6  = R_W'(((64'd1 << K) + 64'd11) / 64'd12);
  localparam logic [R_W-1:0] RCP10 = R_W'(((64'd1 << K) + 64'd19) / 64'd20);

  localparam logic signed [CMP_W-1:0] PRED_MAX = CMP_W'((64'sd1 <<< (wdp_pkg::PRED_W - 1)) - 1);
  localparam logic signed [CMP_W-1:0] PRED_MIN = -CMP_W'(64'sd1 <<< (wdp_pkg::PRED_W - 1));

  logic signed [SUM_W-1:0]  h0, h1, h2, h3, h4;
  logic signed [SUM_W-1:0]  wsum;
  logic signed [SUM_W-1:0]  delta;
  logic                     use_div;
  logic [R_W-1:0]           rcp;
  logic [4:0]               half_den;
  logic [MAG_W-1:0]         mag;
  logic [A_W-1:0]           num;
  logic [A_W+R_W-1:0]       prod;
  logic [MAG_W-1:0]         quo;
  logic signed [PSUM_W-1:0] psum;
  logic signed [CMP_W-1:0]  pext;

  assign h0 = signed'(SUM_W'(hist_i[0]));
  assign h1 = signed'(SUM_W'(hist_i[1]));
  assign h2 = signed'(SUM_W'(hist_i[2]));
  assign h3 = signed'(SUM_W'(hist_i[3]));
  assign h4 = signed'(SUM_W'(hist_i[4]));

  always_comb begin
    use_div  = 1'b1;
    wsum     = '0;
    rcp      = RCP3;
    half_den = 5'd3;
    unique case (count_i)
      wdp_pkg::COUNT_TWO: begin
        use_div = 1'b0;
        wsum    = h0 - h1;
      end
      wdp_pkg::COUNT_THREE: begin
        wsum     = (h0 <<< 1) - h1 - h2;
        rcp      = RCP3;
        half_den = 5'd3;
      end
      wdp_pkg::COUNT_FOUR: begin
        wsum     = (h0 <<< 1) + h0 - h1 - h2 - h3;
        rcp      = RCP6;
        half_den = 5'd6;
      end
      wdp_pkg::COUNT_FULL: begin
        wsum     = (h0 <<< 2) - h1 - h2 - h3 - h4;
        rcp      = RCP10;
        half_den = 5'd10;
      end
      default: begin
        use_div = 1'b0;
        wsum    = '0;
      end
    endcase
  end

  // round half away: (2|s| + d) / (2d), reciprocal is exact over the numerator range
  always_comb begin
    mag   = wsum[SUM_W-1] ? MAG_W'(-wsum) : MAG_W'(wsum);
    num   = {1'b0, mag, 1'b0} + A_W'(half_den);
    prod  = (A_W+R_W)'(num) * (A_W+R_W)'(rcp);
    quo   = prod[K +: MAG_W];
    if (!use_div) begin
      delta = wsum;
    end else if (wsum[SUM_W-1]) begin
      delta = -signed'(SUM_W'(quo));
    end else begin
      delta = signed'(SUM_W'(quo));
    end
    psum = PSUM_W'(h0) + PSUM_W'(delta);
    pext = CMP_W'(psum);
    priority if (pext > PRED_MAX) begin
      pred_o = wdp_pkg::PRED_W'(PRED_MAX);
    end else if (pext < PRED_MIN) begin
      pred_o = wdp_pkg::PRED_W'(PRED_MIN);
    end else begin
      pred_o = wdp_pkg::PRED_W'(pext);
    end
  end

endmodule

// File: rtl/wdp_checker.sv
module wdp_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [wdp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input  logic                              s_axis_tuser,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [wdp_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  localparam int unsigned CW = wdp_pkg::COORD_W;
  localparam int unsigned PW = wdp_pkg::PRED_W;
  localparam int unsigned NW = wdp_pkg::COUNT_W;

  logic          s_acc;
  logic [NW-1:0] held;

  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign held  = m_axis_tdata[2*PW +: NW];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (held != wdp_pkg::COUNT_EMPTY) && (held <= wdp_pkg::COUNT_FULL))
    else $error("points_held out of range");

  a_start_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && s_axis_tuser) ##1 m_axis_tready |=>
      m_axis_tvalid && (held == wdp_pkg::COUNT_ONE) &&
      (m_axis_tdata[PW-1:0] == PW'($past(s_axis_tdata[CW-1:0], 2))) &&
      (m_axis_tdata[2*PW-1:PW] == PW'($past(s_axis_tdata[2*CW-1:CW], 2))))
    else $error("new track does not predict its own center");

endmodule

bind weighted_delta_position_predictor wdp_checker u_wdp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
